### rtl/wedge_pkg.sv
// ----------------------------------------------------------------------------
// wedge_pkg
// Shared types and constants of the 3x3 window edge blackening block.
// ----------------------------------------------------------------------------
package wedge_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 2048;
   localparam int PIX_W       = 24;
   localparam int DIM_W       = 12;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int OROW_W      = $clog2(MAX_HEIGHT);
   localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } border_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] addr;
      logic             zero_shift;
      logic             emit;
      border_type       border;
      logic             last;
   } task_type;

endpackage

### rtl/wedge_ram.sv
// ----------------------------------------------------------------------------
// wedge_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module wedge_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wedge_front.sv
// ----------------------------------------------------------------------------
// wedge_front
// Request intake: frame geometry registers, input and output position
// counters, and classification of each request into a window task.
// ----------------------------------------------------------------------------
module wedge_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [23:0]                        req_tdata,
   input  logic                               req_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wedge_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wedge_pkg::DIM_W-1:0]        csr_data,
   input  logic                               q_full,
   output logic                               q_push,
   output wedge_pkg::task_type                q_task
);

   logic [wedge_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [wedge_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [wedge_pkg::COL_W-1:0]  icol_ff, icol_in;
   logic [wedge_pkg::ROW_W-1:0]  irow_ff, irow_in;
   logic [wedge_pkg::COL_W-1:0]  ocol_ff, ocol_in;
   logic [wedge_pkg::OROW_W-1:0] orow_ff, orow_in;

   logic accept;
   logic in_frame;
   logic drop;
   logic csr_write;

   function automatic logic [wedge_pkg::DIM_W-1:0] clamp_dim(
      input logic [wedge_pkg::DIM_W-1:0] value,
      input logic [wedge_pkg::DIM_W-1:0] max_value
   );
      logic [wedge_pkg::DIM_W-1:0] result;
      if (value == '0) begin
         result = wedge_pkg::DIM_W'(1);
      end else if (value > max_value) begin
         result = max_value;
      end else begin
         result = value;
      end
      return result;
   endfunction

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_frame = (wedge_pkg::ROW_W'(height_ff) > irow_ff);
      drop     = (req_tuser == wedge_pkg::OP_DRAIN) && in_frame;
      q_push   = accept && !drop;

      q_task.pix        = in_frame ? req_tdata : '0;
      q_task.addr       = icol_ff;
      q_task.zero_shift = (icol_ff == '0) && (irow_ff >= wedge_pkg::ROW_W'(2));
      q_task.emit       = (icol_ff == '0) ? (irow_ff >= wedge_pkg::ROW_W'(2))
                                          : (irow_ff >= wedge_pkg::ROW_W'(1));
      q_task.border.top    = (orow_ff == '0);
      q_task.border.bottom = ({1'b0, orow_ff} + wedge_pkg::DIM_W'(1)) >= height_ff;
      q_task.border.left   = (ocol_ff == '0);
      q_task.border.right  = ({1'b0, ocol_ff} + wedge_pkg::DIM_W'(1)) >= width_ff;
      q_task.last = ({1'b0, orow_ff} == (height_ff - wedge_pkg::DIM_W'(1))) &&
                    ({1'b0, ocol_ff} == (width_ff - wedge_pkg::DIM_W'(1)));

      width_in  = width_ff;
      height_in = height_ff;
      icol_in   = icol_ff;
      irow_in   = irow_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;

      if (csr_write) begin
         case (csr_index)
            wedge_pkg::CSR_IMAGE_WIDTH: begin
               width_in = clamp_dim(csr_data, wedge_pkg::DIM_W'(wedge_pkg::MAX_WIDTH));
               icol_in  = '0;
               irow_in  = '0;
               ocol_in  = '0;
               orow_in  = '0;
            end
            wedge_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = clamp_dim(csr_data, wedge_pkg::DIM_W'(wedge_pkg::MAX_HEIGHT));
               icol_in   = '0;
               irow_in   = '0;
               ocol_in   = '0;
               orow_in   = '0;
            end
            default: begin
            end
         endcase
      end else if (q_push) begin
         if (({1'b0, icol_ff} + wedge_pkg::DIM_W'(1)) >= width_ff) begin
            icol_in = '0;
            irow_in = irow_ff + wedge_pkg::ROW_W'(1);
         end else begin
            icol_in = icol_ff + wedge_pkg::COL_W'(1);
         end
         if (q_task.emit) begin
            if (q_task.border.right) begin
               ocol_in = '0;
               orow_in = orow_ff + wedge_pkg::OROW_W'(1);
            end else begin
               ocol_in = ocol_ff + wedge_pkg::COL_W'(1);
            end
            if (q_task.last) begin
               icol_in = '0;
               irow_in = '0;
               ocol_in = '0;
               orow_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= wedge_pkg::DIM_W'(640);
         height_ff <= wedge_pkg::DIM_W'(480);
         icol_ff   <= '0;
         irow_ff   <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         icol_ff   <= icol_in;
         irow_ff   <= irow_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
      end
   end

endmodule

### rtl/wedge_queue.sv
// ----------------------------------------------------------------------------
// wedge_queue
// Short task queue between the request intake and the window datapath.
// ----------------------------------------------------------------------------
module wedge_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wedge_pkg::task_type push_task,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output wedge_pkg::task_type pop_task
);

   wedge_pkg::task_type entry_ff [wedge_pkg::QUEUE_DEPTH];
   logic [wedge_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [wedge_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [wedge_pkg::QPTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (wedge_pkg::QPTR_W+1)'(wedge_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_task  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + wedge_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + wedge_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (wedge_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (wedge_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/wedge_back.sv
// ----------------------------------------------------------------------------
// wedge_back
// Window datapath: line stores, 3x3 window, opposite-pair match test and
// the registered result stage.
// ----------------------------------------------------------------------------
module wedge_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  wedge_pkg::task_type q_task,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast
);

   localparam int PW = wedge_pkg::PIX_W;

   wedge_pkg::task_type s2_task_ff;
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_fire;
   logic                out_free;

   logic          fwd_ff;
   logic [PW-1:0] fwd_top_ff;
   logic [PW-1:0] fwd_mid_ff;

   logic [PW-1:0] upper_rd;
   logic [PW-1:0] middle_rd;
   logic [PW-1:0] top_pix;
   logic [PW-1:0] mid_pix;

   logic [PW-1:0] win_ff [9];
   logic [PW-1:0] win_in [9];
   logic [PW-1:0] rwin [9];
   logic [PW-1:0] nb [9];
   logic [PW-1:0] new_col [3];
   logic [PW-1:0] centre;
   logic          edge_hit;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_pix_ff;
   logic          rsp_edge_ff;
   logic          rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s2_fire  = s2_valid_ff && (!s2_task_ff.emit || out_free);
   assign q_pop    = q_not_empty && (!s2_valid_ff || s2_fire);

   wedge_ram #(
      .WIDTH(PW),
      .DEPTH(wedge_pkg::MAX_WIDTH)
   ) u_upper_ram (
      .clock  (clock),
      .wr_en  (s2_fire),
      .wr_addr(s2_task_ff.addr),
      .wr_data(mid_pix),
      .rd_en  (q_pop),
      .rd_addr(q_task.addr),
      .rd_data(upper_rd)
   );

   wedge_ram #(
      .WIDTH(PW),
      .DEPTH(wedge_pkg::MAX_WIDTH)
   ) u_middle_ram (
      .clock  (clock),
      .wr_en  (s2_fire),
      .wr_addr(s2_task_ff.addr),
      .wr_data(s2_task_ff.pix),
      .rd_en  (q_pop),
      .rd_addr(q_task.addr),
      .rd_data(middle_rd)
   );

   // A task read the line stores while its predecessor wrote the same column.
   assign top_pix = fwd_ff ? fwd_top_ff : upper_rd;
   assign mid_pix = fwd_ff ? fwd_mid_ff : middle_rd;

   always_comb begin
      new_col[0] = top_pix;
      new_col[1] = mid_pix;
      new_col[2] = s2_task_ff.pix;
      for (int r = 0; r < 3; r++) begin
         rwin[r*3+0]   = win_ff[r*3+1];
         rwin[r*3+1]   = win_ff[r*3+2];
         rwin[r*3+2]   = s2_task_ff.zero_shift ? '0 : new_col[r];
         win_in[r*3+0] = s2_task_ff.zero_shift ? win_ff[r*3+2] : win_ff[r*3+1];
         win_in[r*3+1] = s2_task_ff.zero_shift ? '0 : win_ff[r*3+2];
         win_in[r*3+2] = new_col[r];
      end
      centre = rwin[4];
      for (int i = 0; i < 9; i++) begin
         if (((i / 3) == 0 && s2_task_ff.border.top) ||
             ((i / 3) == 2 && s2_task_ff.border.bottom) ||
             ((i % 3) == 0 && s2_task_ff.border.left) ||
             ((i % 3) == 2 && s2_task_ff.border.right)) begin
            nb[i] = centre;
         end else begin
            nb[i] = rwin[i];
         end
      end
      edge_hit = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if ((nb[i] == centre) != (nb[8-i] == centre)) begin
            edge_hit = 1'b1;
         end
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (q_pop) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_fire && s2_task_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s2_task_ff <= q_task;
         fwd_ff     <= s2_fire && (s2_task_ff.addr == q_task.addr);
         fwd_top_ff <= mid_pix;
         fwd_mid_ff <= s2_task_ff.pix;
      end
      if (s2_fire && s2_task_ff.emit) begin
         rsp_pix_ff  <= edge_hit ? '0 : centre;
         rsp_edge_ff <= edge_hit;
         rsp_last_ff <= s2_task_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s2_fire) begin
            for (int i = 0; i < 9; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pix_ff[7:0], rsp_pix_ff[15:8], rsp_pix_ff[23:16]};
   assign rsp_tuser  = rsp_edge_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/window_edge_blacken_3x3_top.sv
// ----------------------------------------------------------------------------
// window_edge_blacken_3x3_top
// 3x3 neighborhood edge detector that blackens edge pixels of an RGB raster.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ stream in raster order, one request per cycle
// while req_tready is high. req_tuser low carries a pixel; high is a drain
// request that flushes the results still pending once the last pixel of the
// frame is in. Each result leaves on the rsp_ stream; rsp_tuser marks an edge
// (pixel forced to black) and rsp_tlast marks the bottom-right pixel, after
// which a new frame begins. The result for a pixel follows it by
// image_width + 1 requests, so a frame of W x H pixels needs W + 1 drain
// requests at its end. Throughput is one request per cycle while the datapath
// does not stall. A completing request passes the task queue and the
// registered line-store read and window stage; its result then waits in the
// output register. The csr_ port writes image_width (index 0) and
// image_height (index 1); a write restarts the frame. The user must make a
// write only while the block is idle; the block itself does not enforce
// this. Reset selects a 640 x 480 frame. The line stores need no clearing
// pass. When rsp_tready is low the output register holds its result, the
// datapath stalls and the four-entry queue fills before req_tready drops.
// ----------------------------------------------------------------------------
module window_edge_blacken_3x3_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,   // in_red, in_green, in_blue
   input  logic                            req_tuser,   // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // out_red, out_green, out_blue
   output logic                            rsp_tuser,   // is_edge
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wedge_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wedge_pkg::DIM_W-1:0]     csr_data
);

   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                q_not_empty;
   logic [23:0]         req_pix;
   wedge_pkg::task_type push_task;
   wedge_pkg::task_type pop_task;

   assign req_pix = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   wedge_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_pix),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_task    (push_task)
   );

   wedge_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_task(push_task),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .pop_task (pop_task)
   );

   wedge_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_task     (pop_task),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### verif/tb_window_edge_blacken_3x3_top.sv
// ----------------------------------------------------------------------------
// tb_window_edge_blacken_3x3_top
// Self-checking bench for the 3x3 window edge blackening block.
// ----------------------------------------------------------------------------
// A raster model in the bench tracks the line stores, the window and the
// four position counters, and predicts each result from the requests that
// the block accepts. Directed frames cover the default size, frame restart
// on a register write, the degenerate 1 x 1 frame, sizes written above the
// largest width and height, ignored drains and dropped pixels. Random frames
// of random size and palette content follow, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_window_edge_blacken_3x3_top;

   localparam int QUIET_LIMIT     = 2000;
   localparam int RANDOM_REQUESTS = 1600;
   localparam logic [wedge_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [wedge_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [23:0] rgb;
      logic        is_edge;
      logic        frame_end;
   } out_pixel_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [23:0]                     req_tdata = '0;
   logic                            req_tuser = wedge_pkg::OP_PIXEL;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [23:0]                     rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [wedge_pkg::CSR_IDX_W-1:0] csr_index = wedge_pkg::CSR_IMAGE_WIDTH;
   logic [wedge_pkg::DIM_W-1:0]     csr_data = '0;

   logic [23:0]   upper_store [wedge_pkg::MAX_WIDTH];
   logic [23:0]   middle_store [wedge_pkg::MAX_WIDTH];
   logic [23:0]   window [9];
   int unsigned   in_col, in_row, out_col, out_row;
   int unsigned   frame_w, frame_h;
   out_pixel_type expected_pixels [$];
   int            working_requests = 0;
   int            fail_count = 0;
   int            quiet_cycles = 0;
   int            stall_left = 0;
   bit            sender_gaps = 1'b0;
   bit            reply_stalls = 1'b0;

   window_edge_blacken_3x3_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input logic [wedge_pkg::DIM_W-1:0] value,
                                             input int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic void restart_counters();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic void reset_model();
      for (int i = 0; i < wedge_pkg::MAX_WIDTH; i++) begin
         upper_store[i]  = '0;
         middle_store[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      frame_w = 640;
      frame_h = 480;
      restart_counters();
   endfunction

   function automatic void apply_register(input logic [wedge_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [wedge_pkg::DIM_W-1:0] value);
      if (idx == wedge_pkg::CSR_IMAGE_WIDTH) begin
         frame_w = clamp_dim(value, wedge_pkg::MAX_WIDTH);
         restart_counters();
      end else if (idx == wedge_pkg::CSR_IMAGE_HEIGHT) begin
         frame_h = clamp_dim(value, wedge_pkg::MAX_HEIGHT);
         restart_counters();
      end
   endfunction

   function automatic void shift_column(input logic [23:0] top_px, input logic [23:0] mid_px,
                                        input logic [23:0] bot_px);
      logic [23:0] column [3];
      column[0] = top_px;
      column[1] = mid_px;
      column[2] = bot_px;
      for (int r = 0; r < 3; r++) begin
         window[r*3]   = window[r*3+1];
         window[r*3+1] = window[r*3+2];
         window[r*3+2] = column[r];
      end
   endfunction

   // Evaluates the window at the output position and queues the result.
   function automatic bit blacken_centre();
      logic [23:0]   centre;
      logic [23:0]   nb [9];
      bit            top_b, bottom_b, left_b, right_b, outside, flag, last_px;
      out_pixel_type res;
      int            r, c;
      centre   = window[4];
      top_b    = (out_row == 0);
      bottom_b = (out_row + 1 >= frame_h);
      left_b   = (out_col == 0);
      right_b  = (out_col + 1 >= frame_w);
      flag     = 1'b0;
      for (int i = 0; i < 9; i++) begin
         r = i / 3;
         c = i % 3;
         outside = (r == 0 && top_b) || (r == 2 && bottom_b) ||
                   (c == 0 && left_b) || (c == 2 && right_b);
         nb[i] = outside ? centre : window[i];
      end
      for (int i = 0; i < 4; i++)
         if ((nb[i] == centre) != (nb[8-i] == centre)) flag = 1'b1;
      last_px = (out_row == frame_h - 1) && (out_col == frame_w - 1);
      res.rgb       = flag ? 24'h000000 : centre;
      res.is_edge   = flag;
      res.frame_end = last_px;
      expected_pixels.push_back(res);
      out_col++;
      if (out_col >= frame_w) begin
         out_col = 0;
         out_row++;
      end
      return last_px;
   endfunction

   function automatic void advance_raster(input logic op, input logic [23:0] rgb);
      logic [23:0] pix, top_px, mid_px;
      int unsigned col, row;
      bit          last_hit;
      pix      = rgb;
      last_hit = 1'b0;
      if (in_row < frame_h) begin
         if (op == wedge_pkg::OP_DRAIN) return;
      end else begin
         pix = '0;
      end
      working_requests++;
      col = in_col;
      row = in_row;
      top_px = upper_store[col];
      mid_px = middle_store[col];
      upper_store[col]  = mid_px;
      middle_store[col] = pix;
      if (col == 0) begin
         if (row >= 2) begin
            shift_column('0, '0, '0);
            last_hit = blacken_centre();
         end
         shift_column(top_px, mid_px, pix);
      end else begin
         shift_column(top_px, mid_px, pix);
         if (row >= 1) last_hit = blacken_centre();
      end
      in_col++;
      if (in_col >= frame_w) begin
         in_col = 0;
         in_row++;
      end
      if (last_hit) restart_counters();
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result();
      out_pixel_type want;
      if (expected_pixels.size() == 0) begin
         $display("%0t: unexpected result, expected none actual %h", $time, rsp_tdata);
         fail_count++;
         return;
      end
      want = expected_pixels.pop_front();
      compare_field("out_red", want.rgb[7:0], rsp_tdata[7:0]);
      compare_field("out_green", want.rgb[15:8], rsp_tdata[15:8]);
      compare_field("out_blue", want.rgb[23:16], rsp_tdata[23:16]);
      compare_field("is_edge", {7'd0, want.is_edge}, {7'd0, rsp_tuser});
      compare_field("last_of_frame", {7'd0, want.frame_end}, {7'd0, rsp_tlast});
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) advance_raster(req_tuser, req_tdata);
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
         if (reply_stalls && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
   end

   task automatic send_request(input logic op, input logic [23:0] rgb);
      int gap;
      gap = sender_gaps ? gap_length() : 0;
      req_tvalid = 1'b0;
      repeat (gap) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = rgb;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic csr_write(input logic [wedge_pkg::CSR_IDX_W-1:0] idx,
                            input logic [wedge_pkg::DIM_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Sends keep pixels of a w x h frame; a full frame is followed by the
   // requests that flush it, and a short one is left for a register write.
   task automatic send_frame(input int w, input int h, input int keep);
      logic [23:0] palette [3];
      for (int i = 0; i < 3; i++) palette[i] = 24'($urandom);
      if ($urandom_range(0, 3) == 0) palette[2] = palette[0];
      for (int n = 0; n < keep; n++) begin
         if ($urandom_range(0, 19) == 0) send_request(wedge_pkg::OP_DRAIN, 24'($urandom));
         if ($urandom_range(0, 6) == 0) send_request(wedge_pkg::OP_PIXEL, 24'($urandom));
         else send_request(wedge_pkg::OP_PIXEL, palette[$urandom_range(0, 2)]);
      end
      if (keep == w * h) begin
         for (int i = 0; i <= w; i++) begin
            if ($urandom_range(0, 4) == 0) send_request(wedge_pkg::OP_PIXEL, 24'($urandom));
            else send_request(wedge_pkg::OP_DRAIN, 24'($urandom));
         end
         if ($urandom_range(0, 9) == 0) send_request(wedge_pkg::OP_DRAIN, 24'($urandom));
      end
   endtask

   task automatic test_write_restarts_frame();
      for (int i = 0; i < 6; i++) send_request(wedge_pkg::OP_PIXEL, 24'($urandom));
      wait_idle();
      csr_write(wedge_pkg::CSR_IMAGE_WIDTH, 12'd3);
      csr_write(wedge_pkg::CSR_IMAGE_HEIGHT, 12'd3);
   endtask

   task automatic test_small_frames();
      logic [23:0] pattern [9] = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000,
                                   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                   24'h000000, 24'hFFFFFF, 24'h123456};
      for (int i = 0; i < 9; i++) begin
         send_request(wedge_pkg::OP_PIXEL, pattern[i]);
         if (i == 4) send_request(wedge_pkg::OP_DRAIN, 24'hFFFFFF);
      end
      send_request(wedge_pkg::OP_DRAIN, 24'h000000);
      send_request(wedge_pkg::OP_PIXEL, 24'hFFFFFF);
      send_request(wedge_pkg::OP_DRAIN, 24'h000000);
      send_request(wedge_pkg::OP_DRAIN, 24'h000000);
      wait_idle();
      csr_write(wedge_pkg::CSR_IMAGE_WIDTH, 12'd0);
      csr_write(wedge_pkg::CSR_IMAGE_HEIGHT, 12'd0);
      send_request(wedge_pkg::OP_PIXEL, 24'hA5C3E1);
      send_request(wedge_pkg::OP_PIXEL, 24'h5A3C1E);
      send_request(wedge_pkg::OP_DRAIN, 24'h000000);
      send_request(wedge_pkg::OP_DRAIN, 24'h000000);
   endtask

   task automatic test_spare_registers();
      wait_idle();
      csr_write(wedge_pkg::CSR_IMAGE_WIDTH, 12'd2);
      csr_write(wedge_pkg::CSR_IMAGE_HEIGHT, 12'd2);
      csr_write(CSR_SPARE_2, 12'hFFF);
      csr_write(CSR_SPARE_3, 12'h000);
      send_frame(2, 2, 4);
   endtask

   task automatic test_dimension_extremes();
      sender_gaps  = 1'b1;
      reply_stalls = 1'b1;
      wait_idle();
      csr_write(wedge_pkg::CSR_IMAGE_WIDTH, 12'hFFF);
      csr_write(wedge_pkg::CSR_IMAGE_HEIGHT, 12'd1);
      send_frame(wedge_pkg::MAX_WIDTH, 1, 60);
      wait_idle();
      csr_write(wedge_pkg::CSR_IMAGE_HEIGHT, 12'd2049);
      csr_write(wedge_pkg::CSR_IMAGE_WIDTH, 12'd1);
      send_frame(1, wedge_pkg::MAX_HEIGHT, 60);
   endtask

   task automatic test_random_frames();
      int goal, w, h, r;
      bit reconfigure;
      goal = working_requests + RANDOM_REQUESTS;
      reconfigure = 1'b1;
      while (working_requests < goal) begin
         if (reconfigure || $urandom_range(0, 9) < 6) begin
            r = $urandom_range(0, 99);
            if (r < 70) w = $urandom_range(1, 16);
            else if (r < 95) w = $urandom_range(17, 64);
            else w = $urandom_range(65, 300);
            h = (r < 95) ? $urandom_range(1, 8) : $urandom_range(1, 3);
            wait_idle();
            if ($urandom_range(0, 1) == 1) begin
               csr_write(wedge_pkg::CSR_IMAGE_WIDTH,
                         wedge_pkg::DIM_W'((w == 1 && $urandom_range(0, 1) == 1) ? 0 : w));
               csr_write(wedge_pkg::CSR_IMAGE_HEIGHT,
                         wedge_pkg::DIM_W'((h == 1 && $urandom_range(0, 1) == 1) ? 0 : h));
            end else begin
               csr_write(wedge_pkg::CSR_IMAGE_HEIGHT, wedge_pkg::DIM_W'(h));
               csr_write(wedge_pkg::CSR_IMAGE_WIDTH, wedge_pkg::DIM_W'(w));
            end
         end
         reconfigure  = 1'b0;
         sender_gaps  = ($urandom_range(0, 9) < 7);
         reply_stalls = ($urandom_range(0, 9) < 7);
         if ($urandom_range(0, 99) < 8) begin
            send_frame(w, h, $urandom_range(0, w * h - 1));
            reconfigure = 1'b1;
         end else begin
            send_frame(w, h, w * h);
         end
      end
   endtask

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_write_restarts_frame();
      test_small_frames();
      test_spare_registers();
      test_dimension_extremes();
      test_random_frames();
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/wedge_pkg.sv
rtl/wedge_ram.sv
rtl/wedge_front.sv
rtl/wedge_queue.sv
rtl/wedge_back.sv
rtl/window_edge_blacken_3x3_top.sv
verif/tb_window_edge_blacken_3x3_top.sv
